// File: rtl/assert_macros.svh
// assertion macros shared by the compensation block
// no dependencies; taken in by the files that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define PSC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `PSC_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/psc_pkg.sv
// types and constants of the pressure sensor compensation block
// no dependencies; used by every module of the block
package psc_pkg;

  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int DivW    = 64;
  localparam int DivRemW = 32;

  localparam logic signed [32:0] PressTfOfs = 33'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic signed [63:0] PressScale = 64'sd3125;
  localparam logic signed [63:0] PressBias  = 64'sd140737488355328;
  localparam logic signed [31:0] HumTfOfs   = 32'sd76800;
  localparam logic signed [31:0] HumRndU    = 32'sd16384;
  localparam logic signed [31:0] HumOfsG    = 32'sd32768;
  localparam logic signed [31:0] HumOfsG2   = 32'sd2097152;
  localparam logic signed [31:0] HumRndG    = 32'sd8192;
  localparam logic signed [31:0] HumMax     = 32'sd419430400;

  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM_A   = 3'd4,
    CFG_HUM_B   = 3'd5
  } psc_cfg_idx_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic        [7:0]  h3;
    logic signed [7:0]  h6;
    logic signed [15:0] h2;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
  } psc_coef_t;

  // classified sample as it waits in the queue
  typedef struct packed {
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic        [19:0] adc_p;
    logic        [15:0] adc_h;
  } psc_item_t;

  // side data that rides along the divider
  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [16:0] hu;
    logic signed [17:0] hg;
    logic               bad;
  } psc_tag_t;

endpackage

// File: rtl/psc_if.sv
// valid/ready channels of the compensation block
// no dependencies
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic        [16:0] humidity_q22_10;
  logic               pressure_invalid;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  pressure_invalid, input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                pressure_invalid, output ready);
endinterface

// File: rtl/psc_fifo.sv
// short queue of classified samples between front and back
// depends on psc_pkg
module psc_fifo import psc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  psc_item_t wdata_i,
  input  logic      pop_i,
  output psc_item_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  psc_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// File: rtl/psc_front.sv
// front end: takes raw samples and forms the temperature differences
// depends on psc_pkg and psc_in_if
module psc_front import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  psc_in_if.sink      in_i,
  input  logic [15:0] t1_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output psc_item_t   q_item_o
);

  logic      vld_q;
  psc_item_t item_q;
  logic      take;

  assign in_i.ready = !vld_q || !q_full_i;
  assign take       = in_i.valid && in_i.ready;
  assign q_push_o   = vld_q && !q_full_i;
  assign q_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (q_push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.d1    <= $signed({1'b0, in_i.raw_temperature[19:3]}) - $signed({1'b0, t1_i, 1'b0});
      item_q.d2    <= $signed({1'b0, in_i.raw_temperature[19:4]}) - $signed({1'b0, t1_i});
      item_q.adc_p <= in_i.raw_pressure;
      item_q.adc_h <= in_i.raw_humidity;
    end
  end

endmodule

// File: rtl/psc_div.sv
// pipelined restoring divider, one quotient bit per stage, carries a tag
// depends on psc_pkg
module psc_div import psc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DivW-1:0]    dividend_i,
  input  logic [DivRemW-1:0] divisor_i,
  input  logic               neg_i,
  input  psc_tag_t           tag_i,
  output logic               valid_o,
  output logic [DivW-1:0]    quot_o,
  output logic               neg_o,
  output psc_tag_t           tag_o
);

  logic [DivW-1:0]    vld_q;
  logic [DivRemW-1:0] rem_q [DivW];
  logic [DivW-1:0]    num_q [DivW];
  logic [DivRemW-1:0] den_q [DivW];
  logic [DivW-1:0]    neg_q;
  psc_tag_t           tag_q [DivW];

  logic [DivRemW-1:0] r_in  [DivW];
  logic [DivW-1:0]    n_in  [DivW];
  logic [DivRemW-1:0] d_in  [DivW];
  logic [DivRemW:0]   trial [DivW];
  logic [DivW-1:0]    v_in, s_in;
  psc_tag_t           t_in  [DivW];

  always_comb begin
    for (int k = 0; k < DivW; k++) begin
      if (k == 0) begin
        r_in[k] = '0;
        n_in[k] = dividend_i;
        d_in[k] = divisor_i;
        v_in[k] = valid_i;
        s_in[k] = neg_i;
        t_in[k] = tag_i;
      end else begin
        r_in[k] = rem_q[k-1];
        n_in[k] = num_q[k-1];
        d_in[k] = den_q[k-1];
        v_in[k] = vld_q[k-1];
        s_in[k] = neg_q[k-1];
        t_in[k] = tag_q[k-1];
      end
      // remainder stays below the divisor, so its top bit is free for the shift
      trial[k] = {r_in[k], n_in[k][DivW-1]} - {1'b0, d_in[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivW; k++) begin
        rem_q[k] <= trial[k][DivRemW] ? {r_in[k][DivRemW-2:0], n_in[k][DivW-1]}
                                      : trial[k][DivRemW-1:0];
        num_q[k] <= {n_in[k][DivW-2:0], !trial[k][DivRemW]};
        den_q[k] <= d_in[k];
        tag_q[k] <= t_in[k];
      end
      neg_q <= s_in;
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quot_o  = num_q[DivW-1];
  assign neg_o   = neg_q[DivW-1];
  assign tag_o   = tag_q[DivW-1];

endmodule

// File: rtl/psc_back.sv
// back end: fine temperature, pressure and humidity pipeline with output register
// depends on psc_pkg, psc_out_if and psc_div
module psc_back import psc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  psc_coef_t  coef_i,
  input  logic       q_empty_i,
  input  psc_item_t  q_item_i,
  output logic       q_pop_o,
  psc_out_if.source  out_o
);

  logic        en;
  logic [10:1] v_q;
  logic [6:1]  pv_q;
  logic        out_v_q;

  assign en      = !out_v_q || out_o.ready;
  assign q_pop_o = en && !q_empty_i;

  // fine temperature
  logic signed [31:0] m1_q, m2_q, a2_q, m3_q, tf_q;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q, ap6_q, ap7_q;
  logic [15:0] ah1_q, ah2_q, ah3_q, ah4_q, ah5_q;
  // pressure front half
  logic signed [31:0] tc4_q, tc5_q, tc6_q, tc7_q, tc8_q, tc9_q, tc10_q;
  logic signed [32:0] pv4_q;
  logic signed [31:0] hx4_q;
  logic signed [63:0] vv5_q, v2a6_q, v36_q, v27_q, v1a7_q, pm8_q, nsub8_q, nn9_q;
  logic signed [48:0] vp5_5_q, vp2_5_q, vp5_6_q, vp2_6_q;
  logic signed [30:0] den9_q;
  logic [63:0]        un10_q;
  logic [30:0]        ud10_q;
  logic               neg10_q, bad10_q;
  // humidity front half
  logic signed [31:0] mh5_q, mh3_q, mh6_q, ga6_q, gb6_q, gm7_q, gc8_q, gd9_q;
  logic signed [16:0] u6_q, u7_q, u8_q, u9_q, u10_q;
  logic signed [17:0] ge10_q;

  logic signed [31:0] t5_sum, u_sum, g_sum;
  logic [20:0]        pbase;

  always_comb begin
    t5_sum = tf_q * 32'sd5 + 32'sd128;
    u_sum  = $signed(32'(ah5_q) << 14) - (32'(coef_i.h4) <<< 20) - mh5_q + HumRndU;
    g_sum  = gd9_q + HumRndG;
    pbase  = PressBase - 21'(ap7_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[9:1], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      m1_q  <= 32'(q_item_i.d1) * 32'(coef_i.t2);
      m2_q  <= 32'(q_item_i.d2) * 32'(q_item_i.d2);
      ap1_q <= q_item_i.adc_p;
      ah1_q <= q_item_i.adc_h;
      // stage 2
      a2_q  <= m1_q >>> 11;
      m3_q  <= (m2_q >>> 12) * 32'(coef_i.t3);
      ap2_q <= ap1_q;
      ah2_q <= ah1_q;
      // stage 3
      tf_q  <= a2_q + (m3_q >>> 14);
      ap3_q <= ap2_q;
      ah3_q <= ah2_q;
      // stage 4
      tc4_q <= t5_sum >>> 8;
      pv4_q <= 33'(tf_q) - PressTfOfs;
      hx4_q <= tf_q - HumTfOfs;
      ap4_q <= ap3_q;
      ah4_q <= ah3_q;
      // stage 5
      vv5_q   <= 64'(pv4_q) * 64'(pv4_q);
      vp5_5_q <= 49'(pv4_q) * 49'(coef_i.p5);
      vp2_5_q <= 49'(pv4_q) * 49'(coef_i.p2);
      mh5_q   <= hx4_q * 32'(coef_i.h5);
      mh3_q   <= hx4_q * $signed(32'(coef_i.h3));
      mh6_q   <= hx4_q * 32'(coef_i.h6);
      tc5_q   <= tc4_q;
      ap5_q   <= ap4_q;
      ah5_q   <= ah4_q;
      // stage 6
      v2a6_q  <= vv5_q * 64'(coef_i.p6);
      v36_q   <= vv5_q * 64'(coef_i.p3);
      vp5_6_q <= vp5_5_q;
      vp2_6_q <= vp2_5_q;
      u6_q    <= 17'(u_sum >>> 15);
      ga6_q   <= (mh3_q >>> 11) + HumOfsG;
      gb6_q   <= mh6_q >>> 10;
      tc6_q   <= tc5_q;
      ap6_q   <= ap5_q;
      // stage 7
      v27_q  <= v2a6_q + (64'(vp5_6_q) <<< 17) + (64'(coef_i.p4) <<< 35);
      v1a7_q <= (v36_q >>> 8) + (64'(vp2_6_q) <<< 12) + PressBias;
      gm7_q  <= gb6_q * ga6_q;
      u7_q   <= u6_q;
      tc7_q  <= tc6_q;
      ap7_q  <= ap6_q;
      // stage 8
      pm8_q   <= v1a7_q * $signed(64'(coef_i.p1));
      nsub8_q <= $signed(64'(pbase) << 31) - v27_q;
      gc8_q   <= (gm7_q >>> 10) + HumOfsG2;
      u8_q    <= u7_q;
      tc8_q   <= tc7_q;
      // stage 9
      den9_q <= 31'(pm8_q >>> 33);
      nn9_q  <= nsub8_q * PressScale;
      gd9_q  <= gc8_q * 32'(coef_i.h2);
      u9_q   <= u8_q;
      tc9_q  <= tc8_q;
      // stage 10: magnitudes and sign for the divider
      un10_q  <= nn9_q[63] ? (64'd0 - nn9_q) : nn9_q;
      ud10_q  <= den9_q[30] ? (31'd0 - den9_q) : den9_q;
      neg10_q <= nn9_q[63] ^ den9_q[30];
      bad10_q <= (den9_q == '0);
      ge10_q  <= 18'(g_sum >>> 14);
      u10_q   <= u9_q;
      tc10_q  <= tc9_q;
    end
  end

  psc_tag_t        div_tag_in, dtag;
  logic            dv, dneg;
  logic [DivW-1:0] uq;

  always_comb begin
    div_tag_in.temp = tc10_q;
    div_tag_in.hu   = u10_q;
    div_tag_in.hg   = ge10_q;
    div_tag_in.bad  = bad10_q;
  end

  psc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v_q[10]),
    .dividend_i (un10_q),
    .divisor_i  ({1'b0, ud10_q}),
    .neg_i      (neg10_q),
    .tag_i      (div_tag_in),
    .valid_o    (dv),
    .quot_o     (uq),
    .neg_o      (dneg),
    .tag_o      (dtag)
  );

  // pressure back half, humidity finishes alongside
  logic signed [63:0] q1_q, q2_q, q3_q, q4_q, q5_q, q13_q, e2m2_q, e2m3_q, e2m4_q, e2m5_q;
  logic        [63:0] pp0_q, sq4_q;
  logic        [31:0] pp1_q;
  logic signed [63:0] e1m5_q, sum6_q;
  logic signed [31:0] x2_1_q, x2_2_q, x2_3_q, x2_4_q, ss3_q, kk4_q;
  logic signed [16:0] hs2_q;
  logic        [16:0] hum5_q, hum6_q;
  logic signed [31:0] tp1_q, tp2_q, tp3_q, tp4_q, tp5_q, tp6_q;
  logic [6:1]         bad_q;

  logic signed [31:0] hv;
  logic        [28:0] hc;
  logic signed [63:0] r;
  logic        [31:0] pres;

  always_comb begin
    hv = x2_4_q - (kk4_q >>> 4);
    if (hv < 0) begin
      hc = '0;
    end else if (hv > HumMax) begin
      hc = 29'(HumMax);
    end else begin
      hc = 29'(hv);
    end
    r = (sum6_q >>> 8) + (64'(coef_i.p7) <<< 4);
    if (bad_q[6] || r[63]) begin
      pres = '0;
    end else if (|r[62:32]) begin
      pres = '1;
    end else begin
      pres = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      pv_q    <= {pv_q[5:1], dv};
      out_v_q <= pv_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // post stage 1
      q1_q   <= dneg ? $signed(64'd0 - uq) : $signed(uq);
      x2_1_q <= 32'(dtag.hu) * 32'(dtag.hg);
      tp1_q  <= dtag.temp;
      bad_q  <= {bad_q[5:1], dtag.bad};
      // post stage 2
      q2_q   <= q1_q;
      q13_q  <= q1_q >>> 13;
      e2m2_q <= q1_q * 64'(coef_i.p8);
      hs2_q  <= 17'(x2_1_q >>> 15);
      x2_2_q <= x2_1_q;
      tp2_q  <= tp1_q;
      // post stage 3: low half of the square from partial products
      pp0_q  <= 64'(q13_q[31:0]) * 64'(q13_q[31:0]);
      pp1_q  <= 32'(q13_q[31:0] * q13_q[63:32]);
      q3_q   <= q2_q;
      e2m3_q <= e2m2_q;
      ss3_q  <= 32'(hs2_q) * 32'(hs2_q);
      x2_3_q <= x2_2_q;
      tp3_q  <= tp2_q;
      // post stage 4
      sq4_q  <= pp0_q + {pp1_q[30:0], 33'd0};
      q4_q   <= q3_q;
      e2m4_q <= e2m3_q;
      kk4_q  <= (ss3_q >>> 7) * $signed(32'(coef_i.h1));
      x2_4_q <= x2_3_q;
      tp4_q  <= tp3_q;
      // post stage 5
      e1m5_q <= $signed(sq4_q) * 64'(coef_i.p9);
      q5_q   <= q4_q;
      e2m5_q <= e2m4_q;
      hum5_q <= hc[28:12];
      tp5_q  <= tp4_q;
      // post stage 6
      sum6_q <= q5_q + (e1m5_q >>> 25) + (e2m5_q >>> 19);
      hum6_q <= hum5_q;
      tp6_q  <= tp5_q;
      // output register
      out_o.temperature_centi <= tp6_q;
      out_o.pressure_q24_8    <= pres;
      out_o.humidity_q22_10   <= hum6_q;
      out_o.pressure_invalid  <= bad_q[6];
    end
  end

  assign out_o.valid = out_v_q;

endmodule

// File: rtl/pressure_sensor_compensation.sv
// Integer compensation of raw temperature, pressure and humidity samples. A new
// sample is taken every clock unless the output is held; results leave in order, one
// per sample, via one front register, the queue, ten arithmetic stages, a 64-stage
// divider producing one quotient bit per stage, six finishing stages and the output
// register. A held output stalls the whole back end; the four-entry queue and the
// front register then take up to five more samples before the input closes. Write
// coefficients through the register port only while no sample is in flight (not
// enforced). A zero pressure divisor gives pressure 0 with pressure_invalid set.
`include "assert_macros.svh"

module pressure_sensor_compensation import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  psc_in_if.sink      in_i,
  psc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i
);

  logic [47:0] temp_q, press_a_q, press_b_q, press_c_q, hum_b_q;
  logic [23:0] hum_a_q;
  psc_coef_t   coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q    <= '0;
      press_a_q <= '0;
      press_b_q <= '0;
      press_c_q <= '0;
      hum_a_q   <= '0;
      hum_b_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:    temp_q    <= cfg_wdata_i;
        CFG_PRESS_A: press_a_q <= cfg_wdata_i;
        CFG_PRESS_B: press_b_q <= cfg_wdata_i;
        CFG_PRESS_C: press_c_q <= cfg_wdata_i;
        CFG_HUM_A:   hum_a_q   <= cfg_wdata_i[23:0];
        CFG_HUM_B:   hum_b_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_q[15:0];
    coef.t2 = $signed(temp_q[31:16]);
    coef.t3 = $signed(temp_q[47:32]);
    coef.p1 = press_a_q[15:0];
    coef.p2 = $signed(press_a_q[31:16]);
    coef.p3 = $signed(press_a_q[47:32]);
    coef.p4 = $signed(press_b_q[15:0]);
    coef.p5 = $signed(press_b_q[31:16]);
    coef.p6 = $signed(press_b_q[47:32]);
    coef.p7 = $signed(press_c_q[15:0]);
    coef.p8 = $signed(press_c_q[31:16]);
    coef.p9 = $signed(press_c_q[47:32]);
    coef.h1 = hum_a_q[7:0];
    coef.h3 = hum_a_q[15:8];
    coef.h6 = $signed(hum_a_q[23:16]);
    coef.h2 = $signed(hum_b_q[15:0]);
    coef.h4 = $signed(hum_b_q[31:16]);
    coef.h5 = $signed(hum_b_q[47:32]);
  end

  logic      q_push, q_pop, q_full, q_empty;
  psc_item_t q_wdata, q_rdata;

  psc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .t1_i     (coef.t1),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wdata)
  );

  psc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  psc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coef_i    (coef),
    .q_empty_i (q_empty),
    .q_item_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  `PSC_ASSERT_NEVER(a_q_overflow, clk_i, rst_ni, q_push && q_full, "queue written while full")
  `PSC_ASSERT_NEVER(a_q_underflow, clk_i, rst_ni, q_pop && q_empty, "queue read while empty")
  `PSC_ASSERT(a_bad_zero, clk_i, rst_ni, out_o.valid && out_o.pressure_invalid |-> out_o.pressure_q24_8 == 32'd0, "invalid pressure not forced to zero")
  `PSC_ASSERT(a_hum_range, clk_i, rst_ni, out_o.valid |-> out_o.humidity_q22_10 <= 17'd102400, "humidity above full scale")

endmodule
